// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the ordered list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define OLAD_ASSERT(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("olad assertion failed");

// Check that a condition implies another in the same cycle.
`define OLAD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olad implication failed");

// Check that a condition implies another in the following cycle.
`define OLAD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olad next-cycle implication failed");

`endif

// ===== sv/olad_pkg.sv =====
// Types and constants of the ordered list block.
package olad_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Command queue between front and back; depth must be a power of two.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SHOW   = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 3'd0,
    ST_ELEMENT = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHOW,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic                    pos_zero;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
  } bk_stat_t;

endpackage

// ===== sv/olad_if.sv =====
// Handshake channels of the ordered list block: input items and result items.
interface olad_in_if;
  logic                              valid;
  logic                              ready;
  logic [olad_pkg::OP_W-1:0]         opcode;
  logic signed [olad_pkg::VAL_W-1:0] value;
  logic [olad_pkg::POS_W-1:0]        position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface olad_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [olad_pkg::VAL_W-1:0]  item_value;
  logic [olad_pkg::STAT_W-1:0]        status;
  logic                               last;

  modport source (output valid, output item_value, output status, output last, input ready);
  modport sink   (input valid, input item_value, input status, input last, output ready);
endinterface

// ===== sv/olad_front.sv =====
// Front end: accepts input items, decodes the opcode and queues commands.
module olad_front (
  olad_in_if.sink          in_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output olad_pkg::cmd_t   q_cmd_o
);

  logic known;

  always_comb begin
    case (in_i.opcode)
      olad_pkg::OP_APPEND,
      olad_pkg::OP_SHOW,
      olad_pkg::OP_DELETE: known = 1'b1;
      default:             known = 1'b0;
    endcase
  end

  assign in_i.ready = !q_full_i;

  // Drop unused opcodes at the door; they cause no result.
  assign q_push_o = in_i.valid && !q_full_i && known;

  assign q_cmd_o.op       = olad_pkg::op_e'(in_i.opcode);
  assign q_cmd_o.value    = in_i.value;
  assign q_cmd_o.position = in_i.position;
  assign q_cmd_o.pos_zero = (in_i.position == '0);

endmodule

// ===== sv/olad_fifo.sv =====
// Short command queue between the front end and the list engine.
module olad_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  olad_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output olad_pkg::cmd_t cmd_o,
  output logic           valid_o
);

  olad_pkg::cmd_t                slot_q [olad_pkg::QDEPTH];
  logic [olad_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [olad_pkg::QPTR_W:0]     fill_q, fill_d;

  assign full_o  = (fill_q == (olad_pkg::QPTR_W + 1)'(olad_pkg::QDEPTH));
  assign valid_o = (fill_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/olad_back.sv =====
// List engine: entry memory, element count, sequencer and result register.
module olad_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  olad_pkg::cmd_t       cmd_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  output olad_pkg::bk_stat_t   stat_o,
  olad_out_if.source           out_o
);

  localparam int unsigned IDX_W = olad_pkg::IDX_W;
  localparam int unsigned CNT_W = olad_pkg::CNT_W;
  localparam int unsigned CMP_W = olad_pkg::CMP_W;
  localparam int unsigned VAL_W = olad_pkg::VAL_W;
  localparam int unsigned POS_W = olad_pkg::POS_W;

  olad_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic signed [VAL_W-1:0] mem [olad_pkg::DEPTH];
  logic signed [VAL_W-1:0] rdata_q;

  logic                    rd_en, wr_en;
  logic [IDX_W-1:0]        rd_addr, wr_addr;
  logic signed [VAL_W-1:0] wr_data;

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_value_q;
  olad_pkg::status_e       out_status_q;
  logic                    out_last_q;

  logic                    emit;
  logic signed [VAL_W-1:0] emit_value;
  olad_pkg::status_e       emit_status;
  logic                    emit_last;

  logic             slot_free, cnt_zero, cnt_full, pos_bad, pos_below, last_c, more_shift;
  logic [CNT_W-1:0] idx_p1, idx_p2;
  logic [CMP_W-1:0] pos_ext, cnt_ext;

  assign slot_free  = !out_valid_q || out_o.ready;
  assign cnt_zero   = (count_q == '0);
  assign cnt_full   = (count_q == CNT_W'(olad_pkg::DEPTH));
  assign pos_ext    = CMP_W'(cmd_i.position);
  assign cnt_ext    = CMP_W'(count_q);
  assign pos_bad    = cmd_i.pos_zero || (pos_ext > cnt_ext);
  assign pos_below  = (pos_ext < cnt_ext);
  assign idx_p1     = {1'b0, idx_q} + CNT_W'(1);
  assign idx_p2     = {1'b0, idx_q} + CNT_W'(2);
  assign last_c     = (idx_p1 == count_q);
  assign more_shift = (idx_p2 < count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      olad_pkg::S_IDLE: begin
        if (cmd_valid_i && !cnt_zero) begin
          if (cmd_i.op == olad_pkg::OP_SHOW) begin
            state_d = olad_pkg::S_SHOW;
          end else if (cmd_i.op == olad_pkg::OP_DELETE && !pos_bad) begin
            state_d = pos_below ? olad_pkg::S_SHIFT : olad_pkg::S_FINISH;
          end
        end
      end
      olad_pkg::S_SHOW: begin
        if (slot_free && last_c) begin
          state_d = olad_pkg::S_IDLE;
        end
      end
      olad_pkg::S_SHIFT: begin
        if (!more_shift) begin
          state_d = olad_pkg::S_FINISH;
        end
      end
      olad_pkg::S_FINISH: begin
        if (slot_free) begin
          state_d = olad_pkg::S_IDLE;
        end
      end
      default: state_d = olad_pkg::S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    cmd_pop_o   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = rdata_q;
    emit        = 1'b0;
    emit_value  = '0;
    emit_status = olad_pkg::ST_DONE;
    emit_last   = 1'b1;
    count_d     = count_q;
    idx_d       = idx_q;
    case (state_q)
      olad_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            olad_pkg::OP_APPEND: begin
              if (slot_free) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
                if (cnt_full) begin
                  emit_status = olad_pkg::ST_FULL;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = IDX_W'(count_q);
                  wr_data = cmd_i.value;
                  count_d = count_q + CNT_W'(1);
                end
              end
            end
            olad_pkg::OP_SHOW: begin
              if (cnt_zero) begin
                if (slot_free) begin
                  emit        = 1'b1;
                  emit_status = olad_pkg::ST_EMPTY;
                  cmd_pop_o   = 1'b1;
                end
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                idx_d   = '0;
              end
            end
            olad_pkg::OP_DELETE: begin
              if (cnt_zero || pos_bad) begin
                if (slot_free) begin
                  emit        = 1'b1;
                  emit_status = cnt_zero ? olad_pkg::ST_EMPTY : olad_pkg::ST_RANGE;
                  cmd_pop_o   = 1'b1;
                end
              end else if (pos_below) begin
                // Fetch the entry after the removed one.
                rd_en   = 1'b1;
                rd_addr = IDX_W'(cmd_i.position);
                idx_d   = IDX_W'(cmd_i.position - POS_W'(1));
              end
            end
            default: ;
          endcase
        end
      end
      olad_pkg::S_SHOW: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_value  = rdata_q;
          emit_status = olad_pkg::ST_ELEMENT;
          emit_last   = last_c;
          if (last_c) begin
            cmd_pop_o = 1'b1;
          end else begin
            idx_d   = IDX_W'(idx_p1);
            rd_en   = 1'b1;
            rd_addr = IDX_W'(idx_p1);
          end
        end
      end
      olad_pkg::S_SHIFT: begin
        // Move one entry toward the head and fetch the next.
        wr_en = 1'b1;
        idx_d = IDX_W'(idx_p1);
        if (more_shift) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(idx_p2);
        end
      end
      olad_pkg::S_FINISH: begin
        if (slot_free) begin
          emit      = 1'b1;
          cmd_pop_o = 1'b1;
          count_d   = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olad_pkg::S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q  <= emit_value;
      out_status_q <= emit_status;
      out_last_q   <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.item_value = out_value_q;
  assign out_o.status     = out_status_q;
  assign out_o.last       = out_last_q;

  assign stat_o.count = count_q;
  assign stat_o.busy  = (state_q != olad_pkg::S_IDLE);

endmodule

// ===== sv/ordered_list_append_delete.sv =====
// Append and error results pass through the command queue and the result register.
// Show: reads the first entry from the entry memory, then one result per cycle while results are taken.
// Delete: moves each entry after the removed one toward the head, then emits the result.
// The engine runs one command at a time with the memory's single read port; new items wait in the queue.
// Reset: asynchronous, active low; empties the list and the command queue.
`include "assert_macros.svh"

module ordered_list_append_delete (
  input  logic        clk_i,
  input  logic        rst_ni,
  olad_in_if.sink     in_ch_i,
  olad_out_if.source  out_ch_o
);

  // Command queue handshake between front end and list engine.
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  olad_pkg::cmd_t     q_cmd_in;
  olad_pkg::cmd_t     q_cmd_out;
  olad_pkg::bk_stat_t bk_stat;

  // Accept items, drop unused opcodes, hand commands to the queue.
  olad_front u_front (
    .in_i     (in_ch_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd_in)
  );

  // Decouple the front end from the engine so each side can stall on its own.
  olad_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd_out),
    .valid_o (q_valid)
  );

  // Execute commands against the entry memory; pop a command as its last result is issued.
  olad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd_out),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .stat_o      (bk_stat),
    .out_o       (out_ch_o)
  );

  // The engine never removes a command that is not there.
  `OLAD_ASSERT_IMP(a_pop_valid, clk_i, rst_ni, q_pop, q_valid)
  // The element count stays within the list depth.
  `OLAD_ASSERT(a_count_bound, clk_i, rst_ni, bk_stat.count <= olad_pkg::CNT_W'(olad_pkg::DEPTH))
  // A command that leaves the idle state only runs on a non-empty list.
  `OLAD_ASSERT_IMP(a_busy_nonempty, clk_i, rst_ni, bk_stat.busy, bk_stat.count != '0)
  // Show streams without a gap: a taken non-final result is followed by the next one.
  `OLAD_ASSERT_NEXT(a_show_stream, clk_i, rst_ni,
    out_ch_o.valid && out_ch_o.ready && !out_ch_o.last, out_ch_o.valid)

endmodule
